// File: hdl/iso2unix_pkg.sv
// Shared widths, the parsed-string record and the small constant tables.
// Used by every module of the date-time to Unix microseconds converter.
package iso2unix_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 88;
  localparam int YEAR_W      = 14;
  localparam int FIELD_W     = 7;
  localparam int FRAC_W      = 20;
  localparam int FCNT_W      = 3;
  localparam int TS_W        = 63;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
    logic [FRAC_W-1:0]  frac;
    logic [FCNT_W-1:0]  fcnt;
    logic               zsign;
    logic [FIELD_W-1:0] zh;
    logic [FIELD_W-1:0] zm;
  } rec_t;

  // Day of the March-based year on which a month starts, by zero-based month.
  function automatic logic [8:0] month_start(input logic [3:0] r);
    logic [8:0] v;
    unique case (r)
      4'd0:    v = 9'd306;
      4'd1:    v = 9'd337;
      4'd2:    v = 9'd0;
      4'd3:    v = 9'd31;
      4'd4:    v = 9'd61;
      4'd5:    v = 9'd92;
      4'd6:    v = 9'd122;
      4'd7:    v = 9'd153;
      4'd8:    v = 9'd184;
      4'd9:    v = 9'd214;
      4'd10:   v = 9'd245;
      4'd11:   v = 9'd275;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Microseconds per unit of the last fraction digit taken.
  function automatic logic [FRAC_W-1:0] frac_scale(input logic [FCNT_W-1:0] n);
    logic [FRAC_W-1:0] v;
    unique case (n)
      3'd0:    v = 20'd1000000;
      3'd1:    v = 20'd100000;
      3'd2:    v = 20'd10000;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd100;
      3'd5:    v = 20'd10;
      default: v = 20'd1;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/iso2unix_front.sv
// Character parser: accumulates the date, time, fraction and zone of one string.
// Pushes one parsed record per string into the queue; uses iso2unix_pkg.
module iso2unix_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [iso2unix_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 q_full,
  output logic                                 push,
  output iso2unix_pkg::rec_t                   push_rec
);

  localparam logic [2:0] PH_FIXED = 3'd0;
  localparam logic [2:0] PH_AFTER = 3'd1;
  localparam logic [2:0] PH_FRAC  = 3'd2;
  localparam logic [2:0] PH_ZONE  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;
  localparam logic [4:0] FIXED_LEN = 5'd19;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;

  logic [4:0]  pos_r,    pos_nxt;
  logic [2:0]  phase_r,  phase_nxt;
  logic [13:0] year_r,   year_nxt;
  logic [6:0]  month_r,  month_nxt;
  logic [6:0]  day_r,    day_nxt;
  logic [6:0]  hour_r,   hour_nxt;
  logic [6:0]  minute_r, minute_nxt;
  logic [6:0]  second_r, second_nxt;
  logic [19:0] frac_r,   frac_nxt;
  logic [2:0]  fcnt_r,   fcnt_nxt;
  logic        zsign_r,  zsign_nxt;
  logic [7:0]  zone_r   [5];
  logic [7:0]  zone_nxt [5];
  logic [2:0]  zcnt_r,   zcnt_nxt;
  logic        err_r,    err_nxt;
  logic        ended_r,  ended_nxt;

  logic        accept;
  logic [7:0]  ch;
  logic [3:0]  dig;
  logic        is_dig;
  logic [4:0]  zdig;
  logic        hh_ok;
  logic [6:0]  hh;
  logic [6:0]  mm;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ch        = in_tdata;
  assign dig       = ch[3:0];
  assign is_dig    = (ch >= CH_ZERO) && (ch <= CH_NINE);

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    frac_nxt   = frac_r;
    fcnt_nxt   = fcnt_r;
    zsign_nxt  = zsign_r;
    zone_nxt   = zone_r;
    zcnt_nxt   = zcnt_r;
    err_nxt    = err_r;
    ended_nxt  = ended_r;
    if (!ended_r) begin
      if (ch == 8'd0) begin
        ended_nxt = 1'b1;
      end else begin
        unique case (phase_r)
          PH_FIXED: begin
            if (!(pos_r == 5'd4 || pos_r == 5'd7 || pos_r == 5'd10 ||
                  pos_r == 5'd13 || pos_r == 5'd16)) begin
              if (!is_dig) begin
                err_nxt = 1'b1;
              end else if (pos_r < 5'd4) begin
                year_nxt = 14'(year_r * 14'd10 + 14'(dig));
              end else if (pos_r < 5'd7) begin
                month_nxt = 7'(month_r * 7'd10 + 7'(dig));
              end else if (pos_r < 5'd10) begin
                day_nxt = 7'(day_r * 7'd10 + 7'(dig));
              end else if (pos_r < 5'd13) begin
                hour_nxt = 7'(hour_r * 7'd10 + 7'(dig));
              end else if (pos_r < 5'd16) begin
                minute_nxt = 7'(minute_r * 7'd10 + 7'(dig));
              end else begin
                second_nxt = 7'(second_r * 7'd10 + 7'(dig));
              end
            end
            pos_nxt = pos_r + 5'd1;
            if (pos_nxt >= FIXED_LEN) begin
              phase_nxt = PH_AFTER;
            end
          end
          PH_AFTER, PH_FRAC: begin
            if (phase_r == PH_AFTER && ch == CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else if (phase_r == PH_FRAC && is_dig) begin
              if (fcnt_r < 3'd6) begin
                frac_nxt = 20'(frac_r * 20'd10 + 20'(dig));
                fcnt_nxt = fcnt_r + 3'd1;
              end
            end else if (ch == CH_PLUS || ch == CH_MINUS) begin
              zsign_nxt = (ch == CH_MINUS);
              phase_nxt = PH_ZONE;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          PH_ZONE: begin
            if (zcnt_r < 3'd5) begin
              zone_nxt[zcnt_r] = ch;
              zcnt_nxt = zcnt_r + 3'd1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      zdig[i] = (zone_nxt[i] >= CH_ZERO) && (zone_nxt[i] <= CH_NINE);
    end
    hh_ok = (zcnt_nxt >= 3'd2) && zdig[0] && zdig[1];
    hh    = 7'(zone_nxt[0][3:0] * 7'd10 + 7'(zone_nxt[1][3:0]));
    mm    = 7'd0;
    if (zcnt_nxt >= 3'd4) begin
      if (zone_nxt[2] == CH_COLON) begin
        if (zcnt_nxt >= 3'd5 && zdig[3] && zdig[4]) begin
          mm = 7'(zone_nxt[3][3:0] * 7'd10 + 7'(zone_nxt[4][3:0]));
        end
      end else if (zdig[2] && zdig[3]) begin
        mm = 7'(zone_nxt[2][3:0] * 7'd10 + 7'(zone_nxt[3][3:0]));
      end
    end
  end

  always_comb begin
    push_rec.ok     = !err_nxt && (phase_nxt != PH_FIXED) && (year_nxt >= 14'd1900) &&
                      (month_nxt >= 7'd1) && (day_nxt >= 7'd1) &&
                      ((phase_nxt != PH_ZONE) || hh_ok);
    push_rec.year   = year_nxt;
    push_rec.month  = month_nxt;
    push_rec.day    = day_nxt;
    push_rec.hour   = hour_nxt;
    push_rec.minute = minute_nxt;
    push_rec.second = second_nxt;
    push_rec.frac   = frac_nxt;
    push_rec.fcnt   = fcnt_nxt;
    push_rec.zsign  = zsign_nxt;
    push_rec.zh     = (phase_nxt == PH_ZONE) ? hh : 7'd0;
    push_rec.zm     = (phase_nxt == PH_ZONE) ? mm : 7'd0;
  end

  assign push = accept && in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      pos_r    <= '0;
      phase_r  <= PH_FIXED;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      frac_r   <= '0;
      fcnt_r   <= '0;
      zsign_r  <= 1'b0;
      zone_r   <= '{default: '0};
      zcnt_r   <= '0;
      err_r    <= 1'b0;
      ended_r  <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      phase_r  <= phase_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      frac_r   <= frac_nxt;
      fcnt_r   <= fcnt_nxt;
      zsign_r  <= zsign_nxt;
      zone_r   <= zone_nxt;
      zcnt_r   <= zcnt_nxt;
      err_r    <= err_nxt;
      ended_r  <= ended_nxt;
    end
  end

endmodule

// File: hdl/iso2unix_queue.sv
// Short first-in first-out queue of parsed records between parser and calculator.
// Depends on iso2unix_pkg for the record type.
module iso2unix_queue #(
  parameter int DEPTH = iso2unix_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  iso2unix_pkg::rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output iso2unix_pkg::rec_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  iso2unix_pkg::rec_t store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: hdl/iso2unix_back.sv
// Epoch calculator: turns one parsed record into Unix microseconds, one
// multiplication per step, and holds the result in the output register.
// Depends on iso2unix_pkg.
module iso2unix_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  iso2unix_pkg::rec_t                   q_head,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [iso2unix_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                 out_tuser
);

  localparam logic [3:0] BK_IDLE = 4'd0;
  localparam logic [3:0] BK_Q12  = 4'd1;
  localparam logic [3:0] BK_YY   = 4'd2;
  localparam logic [3:0] BK_ERA  = 4'd3;
  localparam logic [3:0] BK_YOE  = 4'd4;
  localparam logic [3:0] BK_C100 = 4'd5;
  localparam logic [3:0] BK_DOE  = 4'd6;
  localparam logic [3:0] BK_DAYS = 4'd7;
  localparam logic [3:0] BK_SECS = 4'd8;
  localparam logic [3:0] BK_HOUR = 4'd9;
  localparam logic [3:0] BK_MIN  = 4'd10;
  localparam logic [3:0] BK_ZH   = 4'd11;
  localparam logic [3:0] BK_ZM   = 4'd12;
  localparam logic [3:0] BK_US   = 4'd13;
  localparam logic [3:0] BK_FR   = 4'd14;
  localparam logic [3:0] BK_OUT  = 4'd15;

  localparam int TS_W = iso2unix_pkg::TS_W;
  localparam int YW   = iso2unix_pkg::YEAR_W;
  localparam int FW   = iso2unix_pkg::FIELD_W;
  localparam int PADW = iso2unix_pkg::OUT_TDATA_W - TS_W - YW - FW;

  logic [3:0]          st_r,    st_nxt;
  iso2unix_pkg::rec_t  rec_r,   rec_nxt;
  logic [3:0]          q12_r,   q12_nxt;
  logic [14:0]         yy_r,    yy_nxt;
  logic [8:0]          doy_r,   doy_nxt;
  logic [6:0]          era_r,   era_nxt;
  logic [8:0]          yoe_r,   yoe_nxt;
  logic [2:0]          c100_r,  c100_nxt;
  logic [17:0]         doe_r,   doe_nxt;
  logic signed [25:0]  days_r,  days_nxt;
  logic signed [43:0]  secs_r,  secs_nxt;
  logic signed [57:0]  us_r,    us_nxt;
  logic [39:0]         fr_r,    fr_nxt;
  logic                ov_r,    ov_nxt;
  logic [TS_W-1:0]     ts_r,    ts_nxt;
  logic [YW-1:0]       oyear_r, oyear_nxt;
  logic [FW-1:0]       omon_r,  omon_nxt;
  logic                ouser_r, ouser_nxt;

  logic [6:0]  mon0;
  logic [6:0]  rem12;
  logic [12:0] p12;
  logic [27:0] p400;
  logic [14:0] p100;
  logic [43:0] zoff;
  logic        out_free;

  assign mon0     = rec_r.month - 7'd1;
  assign p12      = 13'(mon0) * 13'd43;
  assign rem12    = 7'(mon0 - 7'(q12_r * 7'd12));
  assign p400     = 28'(yy_r) * 28'd5243;
  assign p100     = 15'(yoe_r) * 15'd41;
  assign out_free = !ov_r || out_tready;
  assign q_pop    = (st_r == BK_IDLE) && !q_empty;

  always_comb begin
    st_nxt    = st_r;
    rec_nxt   = rec_r;
    q12_nxt   = q12_r;
    yy_nxt    = yy_r;
    doy_nxt   = doy_r;
    era_nxt   = era_r;
    yoe_nxt   = yoe_r;
    c100_nxt  = c100_r;
    doe_nxt   = doe_r;
    days_nxt  = days_r;
    secs_nxt  = secs_r;
    us_nxt    = us_r;
    fr_nxt    = fr_r;
    ov_nxt    = ov_r && !out_tready;
    ts_nxt    = ts_r;
    oyear_nxt = oyear_r;
    omon_nxt  = omon_r;
    ouser_nxt = ouser_r;
    zoff      = '0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          rec_nxt = q_head;
          st_nxt  = BK_Q12;
        end
      end
      BK_Q12: begin
        q12_nxt = p12[12:9];
        st_nxt  = BK_YY;
      end
      BK_YY: begin
        yy_nxt  = 15'(rec_r.year) + 15'(q12_r) - 15'(rem12 < 7'd2);
        doy_nxt = iso2unix_pkg::month_start(rem12[3:0]);
        st_nxt  = BK_ERA;
      end
      BK_ERA: begin
        era_nxt = p400[27:21];
        st_nxt  = BK_YOE;
      end
      BK_YOE: begin
        yoe_nxt = 9'(yy_r - 15'(era_r) * 15'd400);
        st_nxt  = BK_C100;
      end
      BK_C100: begin
        c100_nxt = p100[14:12];
        st_nxt   = BK_DOE;
      end
      BK_DOE: begin
        doe_nxt = 18'(yoe_r) * 18'd365 + 18'(yoe_r[8:2]) - 18'(c100_r) + 18'(doy_r);
        st_nxt  = BK_DAYS;
      end
      BK_DAYS: begin
        days_nxt = 26'(era_r) * 26'd146097 + 26'(doe_r) + 26'(rec_r.day) - 26'd719469;
        st_nxt   = BK_SECS;
      end
      BK_SECS: begin
        secs_nxt = {{18{days_r[25]}}, days_r} * 44'd86400;
        st_nxt   = BK_HOUR;
      end
      BK_HOUR: begin
        secs_nxt = secs_r + 44'(rec_r.hour) * 44'd3600;
        st_nxt   = BK_MIN;
      end
      BK_MIN: begin
        secs_nxt = secs_r + 44'(rec_r.minute) * 44'd60 + 44'(rec_r.second);
        st_nxt   = BK_ZH;
      end
      BK_ZH: begin
        zoff     = 44'(rec_r.zh) * 44'd3600;
        secs_nxt = rec_r.zsign ? secs_r + zoff : secs_r - zoff;
        st_nxt   = BK_ZM;
      end
      BK_ZM: begin
        zoff     = 44'(rec_r.zm) * 44'd60;
        secs_nxt = rec_r.zsign ? secs_r + zoff : secs_r - zoff;
        st_nxt   = BK_US;
      end
      BK_US: begin
        us_nxt = {{14{secs_r[43]}}, secs_r} * 58'd15625;
        st_nxt = BK_FR;
      end
      BK_FR: begin
        fr_nxt = 40'(rec_r.frac) * 40'(iso2unix_pkg::frac_scale(rec_r.fcnt));
        st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ouser_nxt = rec_r.ok;
          ts_nxt    = rec_r.ok ? TS_W'({us_r, 6'b0}) + TS_W'(fr_r) : '0;
          oyear_nxt = rec_r.ok ? rec_r.year : '0;
          omon_nxt  = rec_r.ok ? rec_r.month : '0;
          st_nxt    = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    q12_r   <= q12_nxt;
    yy_r    <= yy_nxt;
    doy_r   <= doy_nxt;
    era_r   <= era_nxt;
    yoe_r   <= yoe_nxt;
    c100_r  <= c100_nxt;
    doe_r   <= doe_nxt;
    days_r  <= days_nxt;
    secs_r  <= secs_nxt;
    us_r    <= us_nxt;
    fr_r    <= fr_nxt;
    ts_r    <= ts_nxt;
    oyear_r <= oyear_nxt;
    omon_r  <= omon_nxt;
    ouser_r <= ouser_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ouser_r;
  assign out_tdata  = {PADW'(0), omon_r, oyear_r, ts_r};

endmodule

// File: hdl/iso8601_to_unix_microseconds.sv
// Top level of the ISO 8601 date-time to Unix microseconds converter.
// Instantiates iso2unix_front, iso2unix_queue and iso2unix_back; uses iso2unix_pkg.
//
// The input stream carries one text byte per transaction in in_tdata, with
// in_tlast on the final byte of each string. A zero byte ends the text early;
// bytes after it are still consumed up to in_tlast. Each string gives exactly
// one result transaction: out_tuser is the valid flag, out_tdata holds the
// timestamp, year and month, all zero when the parse fails.
// The parser takes one byte per cycle while in_tready is high. After the
// final byte, the calculator works through its states, one multiplication
// per step, and registers the result when the output is free; it takes the
// next string only when done with the last. A queue of QUEUE_DEPTH parsed
// strings sits between parser and calculator; in_tready falls only while
// that queue is full. A stalled result waits in the output register and
// holds the calculator, which then stops taking strings from the queue.
// Reset is synchronous: it empties the queue, drops out_tvalid and clears
// the parser, so the next byte is taken as the first of a string.
module iso8601_to_unix_microseconds #(
  parameter int QUEUE_DEPTH = iso2unix_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [iso2unix_pkg::IN_TDATA_W-1:0]  in_tdata,  // [7:0] character
  input  logic                                 in_tlast,  // end_of_string
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [62:0] timestamp_us, [76:63] year, [83:77] month, [87:84] zero
  output logic [iso2unix_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                                 out_tuser  // valid_res
);

  logic               push;
  iso2unix_pkg::rec_t push_rec;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;
  iso2unix_pkg::rec_t q_head;

  iso2unix_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_rec  (push_rec)
  );

  iso2unix_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  iso2unix_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// File: hdl/iso2unix_chk.sv
// Port-level checker for the date-time converter, bound to the top level.
// Depends on iso2unix_pkg for the output width.
module iso2unix_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [iso2unix_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                                 out_tuser
);

  // No result may be offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A failed parse reports zeros in every field.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("failed parse with non-zero data");

  // A successful parse has a year from 1900 on and a month of at least one.
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[76:63] >= 14'd1900 && out_tdata[83:77] != 7'd0)
    else $error("valid result with year or month out of range");

endmodule

bind iso8601_to_unix_microseconds iso2unix_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/tb_iso8601_to_unix_microseconds.sv
// Self-checking testbench for the ISO 8601 date-time to Unix microseconds converter.
// Streams directed and random date-time strings; checks each result against a typed
// value or a local predictor; depends on iso2unix_pkg, iso8601_to_unix_microseconds.
module tb_iso8601_to_unix_microseconds;
  timeunit 1ns;
  timeprecision 1ps;

  import iso2unix_pkg::*;

  localparam int YEAR_LSB  = TS_W;
  localparam int MONTH_LSB = TS_W + YEAR_W;
  localparam int PAD_LSB   = TS_W + YEAR_W + FIELD_W;
  localparam int FIXED_LEN = 19;
  localparam int YEAR_MIN  = 1900;
  localparam int ZONE_KEEP = 5;

  localparam byte unsigned CH_NUL   = 8'h00;
  localparam byte unsigned CH_ZERO  = "0";
  localparam byte unsigned CH_NINE  = "9";
  localparam byte unsigned CH_DOT   = ".";
  localparam byte unsigned CH_PLUS  = "+";
  localparam byte unsigned CH_MINUS = "-";
  localparam byte unsigned CH_COLON = ":";

  typedef enum logic [2:0] {
    STAGE_FIELDS,
    STAGE_TAIL,
    STAGE_FRACTION,
    STAGE_ZONE,
    STAGE_IGNORE
  } stage_t;

  typedef struct packed {
    logic               ok;
    logic [TS_W-1:0]    micros;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
  } stamp_t;

  typedef struct {
    string  text;
    int     nul_at;
    bit     typed;
    stamp_t want;
  } vector_t;

  localparam stamp_t REJECT = '0;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  iso8601_to_unix_microseconds u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  stamp_t  expected_stamps[$];
  vector_t directed_rows[$];
  int      mismatches = 0;
  int      hold_left  = 0;
  bit      calm       = 1'b0;

  // Parser state of the predictor.
  int           text_pos;
  stage_t       stage;
  int           acc_year, acc_month, acc_day, acc_hour, acc_min, acc_sec;
  int           acc_frac, frac_digits;
  bit           zone_west;
  byte unsigned zone_buf[ZONE_KEEP];
  int           zone_len;
  bit           digit_error, text_done;

  function automatic bit is_num(byte unsigned c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_parser();
    text_pos = 0;
    stage = STAGE_FIELDS;
    acc_year = 0; acc_month = 0; acc_day = 0;
    acc_hour = 0; acc_min = 0; acc_sec = 0;
    acc_frac = 0; frac_digits = 0;
    zone_west = 1'b0;
    foreach (zone_buf[k]) zone_buf[k] = CH_NUL;
    zone_len = 0;
    digit_error = 1'b0;
    text_done = 1'b0;
  endfunction

  function automatic void leave_number(byte unsigned c);
    if (c == CH_PLUS || c == CH_MINUS) begin
      zone_west = (c == CH_MINUS);
      stage = STAGE_ZONE;
    end else begin
      stage = STAGE_IGNORE;
    end
  endfunction

  function automatic void parse_char(byte unsigned c);
    int d;
    d = int'(c) - int'(CH_ZERO);
    case (stage)
      STAGE_FIELDS: begin
        if (!(text_pos inside {4, 7, 10, 13, 16})) begin
          if (!is_num(c)) digit_error = 1'b1;
          else if (text_pos < 4) acc_year = acc_year * 10 + d;
          else if (text_pos < 7) acc_month = acc_month * 10 + d;
          else if (text_pos < 10) acc_day = acc_day * 10 + d;
          else if (text_pos < 13) acc_hour = acc_hour * 10 + d;
          else if (text_pos < 16) acc_min = acc_min * 10 + d;
          else acc_sec = acc_sec * 10 + d;
        end
        text_pos++;
        if (text_pos >= FIXED_LEN) stage = STAGE_TAIL;
      end
      STAGE_TAIL: begin
        if (c == CH_DOT) stage = STAGE_FRACTION;
        else leave_number(c);
      end
      STAGE_FRACTION: begin
        if (is_num(c)) begin
          if (frac_digits < 6) begin
            acc_frac = acc_frac * 10 + d;
            frac_digits++;
          end
        end else begin
          leave_number(c);
        end
      end
      STAGE_ZONE: begin
        if (zone_len < ZONE_KEEP) begin
          zone_buf[zone_len] = c;
          zone_len++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic bit zone_pair(input int at, output int val);
    val = 0;
    if (at + 2 > zone_len || at + 2 > ZONE_KEEP) return 1'b0;
    if (!is_num(zone_buf[at]) || !is_num(zone_buf[at + 1])) return 1'b0;
    val = (int'(zone_buf[at]) - int'(CH_ZERO)) * 10 + (int'(zone_buf[at + 1]) - int'(CH_ZERO));
    return 1'b1;
  endfunction

  function automatic longint days_since_epoch(longint y, longint m, longint d);
    longint yy, era, yoe, doy, doe;
    yy  = y - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic stamp_t close_string();
    stamp_t r;
    bit     ok;
    int     hh, mm, at;
    longint offs, mon0, y, m, days, secs, us, scale;
    r = REJECT;
    offs = 0;
    hh = 0;
    mm = 0;
    ok = !digit_error && stage != STAGE_FIELDS && acc_year >= YEAR_MIN &&
         acc_month >= 1 && acc_day >= 1;
    if (stage == STAGE_ZONE) begin
      if (!zone_pair(0, hh)) ok = 1'b0;
      if (zone_len >= 4) begin
        at = (zone_buf[2] == CH_COLON) ? 3 : 2;
        if (!zone_pair(at, mm)) mm = 0;
      end
      offs = longint'(hh) * 3600 + longint'(mm) * 60;
      if (zone_west) offs = -offs;
    end
    if (ok) begin
      mon0  = longint'(acc_month) - 1;
      y     = longint'(acc_year) + mon0 / 12;
      m     = mon0 % 12 + 1;
      days  = days_since_epoch(y, m, 1) + longint'(acc_day) - 1;
      secs  = days * 86400 + longint'(acc_hour) * 3600 + longint'(acc_min) * 60 +
              longint'(acc_sec);
      scale = 1;
      repeat (6 - frac_digits) scale = scale * 10;
      us    = (secs - offs) * 1000000 + longint'(acc_frac) * scale;
      r.ok     = 1'b1;
      r.micros = us[TS_W-1:0];
      r.year   = acc_year[YEAR_W-1:0];
      r.month  = acc_month[FIELD_W-1:0];
    end
    clear_parser();
    return r;
  endfunction

  function automatic bit take_byte(input byte unsigned c, input bit last, output stamp_t res);
    res = REJECT;
    if (!text_done) begin
      if (c == CH_NUL) text_done = 1'b1;
      else parse_char(c);
    end
    if (!last) return 1'b0;
    res = close_string();
    return 1'b1;
  endfunction

  function automatic void add_row(string text, int nul_at, bit typed, stamp_t want);
    vector_t v;
    v.text   = text;
    v.nul_at = nul_at;
    v.typed  = typed;
    v.want   = want;
    directed_rows.push_back(v);
  endfunction

  function automatic void append_digits(ref byte unsigned q[$], input int value, input int n);
    byte unsigned t[$];
    int v;
    v = value;
    repeat (n) begin
      t.push_front(8'(int'(CH_ZERO) + v % 10));
      v = v / 10;
    end
    foreach (t[k]) q.push_back(t[k]);
  endfunction

  function automatic bit rare();
    return $urandom_range(0, 7) == 0;
  endfunction

  function automatic byte unsigned pick_separator();
    case ($urandom_range(0, 3))
      0: return CH_MINUS;
      1: return CH_COLON;
      2: return "T";
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic void random_text(ref byte unsigned q[$]);
    int flaw, pos, n;
    q.delete();
    flaw = ($urandom_range(0, 99) < 78) ? 0 : $urandom_range(1, 5);
    append_digits(q, (flaw == 1) ? $urandom_range(0, YEAR_MIN - 1) :
                  $urandom_range(YEAR_MIN, 9999), 4);
    q.push_back(pick_separator());
    append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(1, 12), 2);
    q.push_back(pick_separator());
    append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(1, 28), 2);
    q.push_back(pick_separator());
    append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(0, 23), 2);
    q.push_back(pick_separator());
    append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    q.push_back(pick_separator());
    append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
    if (flaw == 2) begin
      pos = $urandom_range(0, 1) ? 5 : 8;
      q[pos] = CH_ZERO;
      q[pos + 1] = CH_ZERO;
    end
    if (flaw == 3) begin
      pos = $urandom_range(0, FIXED_LEN - 1);
      if (pos inside {4, 7, 10, 13, 16}) pos++;
      do q[pos] = 8'($urandom_range(1, 255)); while (is_num(q[pos]));
    end
    if ($urandom_range(0, 9) < 4) begin
      q.push_back(CH_DOT);
      repeat ($urandom_range(0, 9)) append_digits(q, $urandom_range(0, 9), 1);
    end
    case ($urandom_range(0, 6))
      1: q.push_back($urandom_range(0, 1) ? "Z" : "z");
      2, 3, 4: begin
        q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(0, 14), 2);
        if (!q[q.size() - 1][0] || rare()) q.push_back(CH_COLON);
        append_digits(q, rare() ? $urandom_range(0, 99) : $urandom_range(0, 59), 2);
      end
      5: begin
        q.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 2))
            0: q.push_back(CH_COLON);
            1: append_digits(q, $urandom_range(0, 9), 1);
            default: q.push_back(8'($urandom_range(1, 255)));
          endcase
        end
      end
      6: q.push_back(8'($urandom_range(1, 255)));
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
    if (flaw == 4) begin
      n = $urandom_range(1, FIXED_LEN - 1);
      while (q.size() > n) void'(q.pop_back());
    end
    if (flaw == 5) q[$urandom_range(0, q.size() - 1)] = CH_NUL;
  endfunction

  task automatic send_string(input byte unsigned txt[$], input bit typed, input stamp_t typed_res);
    stamp_t got;
    bit     last;
    for (int i = 0; i < txt.size(); i++) begin
      last = (i == txt.size() - 1);
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= txt[i];
      in_tlast  <= last;
      do @(posedge clk); while (!in_tready);
      if (take_byte(txt[i], last, got)) expected_stamps.push_back(typed ? typed_res : got);
    end
  endtask

  task automatic wait_drained();
    while (expected_stamps.size() != 0) @(posedge clk);
  endtask

  task automatic report(string what, logic signed [63:0] want, logic signed [63:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(0, 17);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    stamp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_stamps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual tuser %b tdata %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = expected_stamps.pop_front();
        if (out_tuser !== want.ok) report("valid flag", want.ok, out_tuser);
        if (out_tdata[TS_W-1:0] !== want.micros)
          report("timestamp", $signed(want.micros), $signed(out_tdata[TS_W-1:0]));
        if (out_tdata[MONTH_LSB-1:YEAR_LSB] !== want.year)
          report("year", want.year, out_tdata[MONTH_LSB-1:YEAR_LSB]);
        if (out_tdata[PAD_LSB-1:MONTH_LSB] !== want.month)
          report("month", want.month, out_tdata[PAD_LSB-1:MONTH_LSB]);
        if (out_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0)
          report("padding", 0, out_tdata[OUT_TDATA_W-1:PAD_LSB]);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    byte unsigned txt[$];
    int           sent, strings;
    clear_parser();
    add_row("1970-01-01T00:00:00Z", -1, 1'b1, stamp_t'{1'b1, 63'd0, 14'd1970, 7'd1});
    add_row("1969-12-31T23:59:59Z", -1, 1'b1,
            stamp_t'{1'b1, -63'sd1000000, 14'd1969, 7'd12});
    add_row("1899-12-31T23:59:59Z", -1, 1'b1, REJECT);
    add_row("2000-00-10T00:00:00", -1, 1'b1, REJECT);
    add_row("2000-01-00T00:00:00", -1, 1'b1, REJECT);
    add_row("2000-01-01T00:00:0", -1, 1'b1, REJECT);
    add_row("2000-01-01T0a:00:00", -1, 1'b1, REJECT);
    add_row("2000-01-01T00:00:00+1", -1, 1'b1, REJECT);
    add_row("2000-01-01T00:00:00-", -1, 1'b1, REJECT);
    add_row("2000-01-01T00:00:00Z", 10, 1'b1, REJECT);
    add_row("0", 0, 1'b1, REJECT);
    add_row("1900-01-01T00:00:00+99:99", -1, 1'b0, REJECT);
    add_row("9999-99-99T99:99:99.999999-99:99", -1, 1'b0, REJECT);
    add_row("1970-01-01T00:00:00.123456789", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00+05:3", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00+0530", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00-05:30", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00+05", -1, 1'b0, REJECT);
    add_row("2000-02-29 12:34:56x+05", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00.5z", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00+01:00junk", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00.+02", -1, 1'b0, REJECT);
    add_row("2000-01-01T00:00:00Z", 19, 1'b0, REJECT);
    add_row("2024-13-01T00:00:00+05:x0", -1, 1'b0, REJECT);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    sent = 0;
    strings = 0;
    foreach (directed_rows[r]) begin
      txt.delete();
      for (int i = 0; i < directed_rows[r].text.len(); i++)
        txt.push_back((i == directed_rows[r].nul_at) ? CH_NUL : directed_rows[r].text[i]);
      send_string(txt, directed_rows[r].typed, directed_rows[r].want);
      sent += txt.size();
    end
    in_tvalid <= 1'b0;
    wait_drained();

    while (sent < 1150) begin
      calm = (sent >= 950);
      random_text(txt);
      send_string(txt, 1'b0, REJECT);
      sent += txt.size();
      strings++;
      if (strings == 20) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
